// File: hdl/vq_codeword_histogram_assert.svh
// ----------------------------------------------------------------------------
// vq_codeword_histogram assertion macros
// Concurrent assertion helpers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef VQ_CODEWORD_HISTOGRAM_ASSERT_SVH
`define VQ_CODEWORD_HISTOGRAM_ASSERT_SVH
`ifndef SYNTHESIS
`define VQCH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("vqch assertion failed");
`define VQCH_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("vqch forbidden condition");
`else
`define VQCH_ASSERT(lbl, clk, rstn, prop)
`define VQCH_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: hdl/vqch_pkg.sv
// ----------------------------------------------------------------------------
// vqch_pkg
// Types and constants of the nearest-codeword histogram block.
// ----------------------------------------------------------------------------
package vqch_pkg;

  localparam int DIV_STEPS = 17;
  localparam int CNT_W     = 24;
  localparam int DIST_W    = 40;
  localparam int FRAC_W    = 17;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] MODE_CB_WRITE = 2'd0;
  localparam logic [1:0] MODE_FEATURE  = 2'd1;
  localparam logic [1:0] MODE_EMIT     = 2'd2;

  localparam logic [1:0] CFG_CODEBOOK_SIZE = 2'd0;
  localparam logic [1:0] CFG_VECTOR_DIM    = 2'd1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_BIN    = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         entry_index;
    logic [3:0]         element_index;
    logic signed [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    logic [5:0]        codeword;
    logic [DIST_W-1:0] min_distance;
    logic [CNT_W-1:0]  bin_count;
    logic [FRAC_W-1:0] bin_fraction;
    logic              empty_res;
    logic              last;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] num;
    logic [CNT_W-1:0] den;
  } div_req_t;

endpackage

// File: hdl/vq_codeword_histogram.sv
// ----------------------------------------------------------------------------
// vq_codeword_histogram
// Nearest-codeword search over a Q8.8 codebook with a saturating histogram.
// ----------------------------------------------------------------------------
// channel  | direction | handshake              | beat
// command  | in        | start & !busy          | cmd_i
// result   | out       | res_valid_o (strobe)   | res_o
// config   | in        | cfg_valid_i&cfg_ready_o| cfg_index_i, cfg_data_i
//
// Codeword write, ignored feature element, unused mode: taken in idle, no search.
// Completed vector: one difference-square-accumulate unit visits each codebook
// element in turn.
// Histogram emit: each bin's fraction comes from the bit-serial divider, which
// is skipped when no vectors were counted.
// Reset clears counts by valid bits; no sweep. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "vq_codeword_histogram_assert.svh"

module vq_codeword_histogram #(
  parameter int MAX_CODEWORDS = 64,
  parameter int MAX_DIM       = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  vqch_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  output vqch_pkg::res_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [6:0]     cfg_data_i
);
  import vqch_pkg::*;

  localparam int CW    = $clog2(MAX_CODEWORDS);
  localparam int NW    = $clog2(MAX_CODEWORDS + 1);
  localparam int VW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CB_AW = $clog2(MAX_CODEWORDS * MAX_DIM);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_MUL  = 10'b0000000100,
    S_ACC  = 10'b0000001000,
    S_CMP  = 10'b0000010000,
    S_BRD  = 10'b0000100000,
    S_BWR  = 10'b0001000000,
    S_HRD  = 10'b0010000000,
    S_HLD  = 10'b0100000000,
    S_HDIV = 10'b1000000000
  } state_e;

  state_e            state_q, state_d;
  logic [6:0]        cs_q;
  logic [4:0]        vd_q;
  logic [NW-1:0]     n_used;
  logic [DW-1:0]     d_used;
  logic [CW-1:0]     j_q, bidx_q;
  logic [VW-1:0]     e_q;
  logic [32:0]       sq_q;
  logic [DIST_W-1:0] acc_q, best_q;
  logic [CNT_W-1:0]  total_q, cnt_q, cnt_rd, cnt_inc;
  logic              emitting_q;
  res_t              res_q;
  logic              res_valid_q;

  logic [15:0]       cb_mem [MAX_CODEWORDS*MAX_DIM];
  logic [15:0]       cb_rd_q;
  logic [CB_AW-1:0]  cb_waddr, cb_raddr;
  logic [15:0]       vbuf_q [MAX_DIM];
  logic [CNT_W-1:0]  bc_mem [MAX_CODEWORDS];
  logic [CNT_W-1:0]  bc_rd_q;
  logic [MAX_CODEWORDS-1:0] bc_valid_q;
  logic [CW-1:0]     bc_raddr;

  logic              accept, cb_we, elem_ok, j_last, e_last;
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  div_req_t          div_req;
  logic              div_done;
  logic [FRAC_W-1:0] div_quo;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE) || emitting_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cs_q == '0) n_used = NW'(1);
    else if (int'(cs_q) > MAX_CODEWORDS) n_used = NW'(MAX_CODEWORDS);
    else n_used = NW'(cs_q);
    if (vd_q == '0) d_used = DW'(1);
    else if (int'(vd_q) > MAX_DIM) d_used = DW'(MAX_DIM);
    else d_used = DW'(vd_q);
  end

  assign j_last  = j_q == CW'(n_used - NW'(1));
  assign e_last  = e_q == VW'(d_used - DW'(1));
  assign elem_ok = int'(cmd_i.element_index) < MAX_DIM;
  assign cb_we   = accept && cmd_i.mode == MODE_CB_WRITE && elem_ok
                   && int'(cmd_i.entry_index) < MAX_CODEWORDS;
  assign cb_waddr = CB_AW'(int'(cmd_i.entry_index) * MAX_DIM
                           + int'(cmd_i.element_index));
  assign cb_raddr = CB_AW'(int'(j_q) * MAX_DIM + int'(e_q));
  assign bc_raddr = (state_q == S_BRD || state_q == S_BWR) ? bidx_q : j_q;

  always_ff @(posedge clk_i) begin
    if (cb_we) cb_mem[cb_waddr] <= cmd_i.value;
    cb_rd_q <= cb_mem[cb_raddr];
    bc_rd_q <= bc_mem[bc_raddr];
    if (state_q == S_BWR) bc_mem[bidx_q] <= cnt_inc;
    if (accept && cmd_i.mode == MODE_FEATURE && elem_ok)
      vbuf_q[VW'(cmd_i.element_index)] <= cmd_i.value;
  end

  assign diff   = $signed({vbuf_q[e_q][15], vbuf_q[e_q]})
                  - $signed({cb_rd_q[15], cb_rd_q});
  assign prod   = diff * diff;
  assign cnt_rd = bc_valid_q[bc_raddr] ? bc_rd_q : '0;
  assign cnt_inc = (cnt_rd == COUNT_MAX) ? COUNT_MAX : cnt_rd + CNT_W'(1);

  assign div_req.start = (state_q == S_HLD) && (total_q != '0);
  assign div_req.num   = cnt_rd;
  assign div_req.den   = total_q;

  vqch_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (emitting_q) state_d = j_last ? S_IDLE : S_HRD;
        else if (accept && cmd_i.mode == MODE_FEATURE && elem_ok
            && int'(cmd_i.element_index) == int'(d_used) - 1) state_d = S_RD;
        else if (accept && cmd_i.mode == MODE_EMIT) state_d = S_HRD;
      end
      S_RD:   state_d = S_MUL;
      S_MUL:  state_d = S_ACC;
      S_ACC:  state_d = e_last ? S_CMP : S_RD;
      S_CMP:  state_d = j_last ? S_BRD : S_RD;
      S_BRD:  state_d = S_BWR;
      S_BWR:  state_d = S_IDLE;
      S_HRD:  state_d = S_HLD;
      S_HLD:  state_d = (total_q == '0) ? S_IDLE : S_HDIV;
      S_HDIV: state_d = div_done ? S_IDLE : S_HDIV;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cs_q        <= 7'd1;
      vd_q        <= 5'd1;
      j_q         <= '0;
      e_q         <= '0;
      bidx_q      <= '0;
      acc_q       <= '0;
      best_q      <= '0;
      sq_q        <= '0;
      cnt_q       <= '0;
      total_q     <= '0;
      bc_valid_q  <= '0;
      emitting_q  <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_CODEBOOK_SIZE) cs_q <= cfg_data_i;
        else if (cfg_index_i == CFG_VECTOR_DIM) vd_q <= cfg_data_i[4:0];
      end
      case (state_q)
        S_IDLE: begin
          j_q   <= '0;
          e_q   <= '0;
          acc_q <= '0;
          if (emitting_q) begin
            res_valid_q        <= 1'b1;
            res_q.kind         <= KIND_BIN;
            res_q.codeword     <= 6'(j_q);
            res_q.min_distance <= '0;
            res_q.bin_count    <= cnt_q;
            res_q.bin_fraction <= (total_q == '0) ? '0 : div_quo;
            res_q.empty_res    <= total_q == '0;
            res_q.last         <= j_last;
            if (j_last) begin
              emitting_q <= 1'b0;
              bc_valid_q <= '0;
              total_q    <= '0;
            end else begin
              j_q <= j_q + CW'(1);
            end
          end
        end
        S_MUL: sq_q <= 33'(unsigned'(prod));
        S_ACC: begin
          acc_q <= acc_q + DIST_W'(sq_q);
          if (!e_last) e_q <= e_q + VW'(1);
        end
        S_CMP: begin
          if (j_q == '0 || acc_q < best_q) begin
            best_q <= acc_q;
            bidx_q <= j_q;
          end
          acc_q <= '0;
          e_q   <= '0;
          if (!j_last) j_q <= j_q + CW'(1);
        end
        S_BWR: begin
          bc_valid_q[bidx_q] <= 1'b1;
          total_q <= (total_q == COUNT_MAX) ? COUNT_MAX : total_q + CNT_W'(1);
          res_valid_q        <= 1'b1;
          res_q.kind         <= KIND_REPORT;
          res_q.codeword     <= 6'(bidx_q);
          res_q.min_distance <= best_q;
          res_q.bin_count    <= cnt_inc;
          res_q.bin_fraction <= '0;
          res_q.empty_res    <= 1'b0;
          res_q.last         <= 1'b0;
        end
        S_HLD: begin
          cnt_q      <= cnt_rd;
          emitting_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `VQCH_ASSERT(a_res_from_work, clk_i, rst_ni, res_valid_o |-> $past(busy))
  `VQCH_ASSERT_NEVER(a_last_idle, clk_i, rst_ni, res_valid_o && res_o.last && busy)
  `VQCH_ASSERT_NEVER(a_report_cnt, clk_i, rst_ni,
                     res_valid_o && res_o.kind == KIND_REPORT && res_o.bin_count == '0)
  `VQCH_ASSERT_NEVER(a_frac_max, clk_i, rst_ni,
                     res_valid_o && res_o.bin_fraction > 17'd65536)

endmodule

// File: hdl/vqch_div.sv
// ----------------------------------------------------------------------------
// vqch_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den),
// valid for num <= den.
// ----------------------------------------------------------------------------
module vqch_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vqch_pkg::div_req_t               req_i,
  output logic                             done_o,
  output logic [vqch_pkg::FRAC_W-1:0]      quo_o
);
  import vqch_pkg::*;

  logic [CNT_W:0]    r_q, r_d, rsub;
  logic [CNT_W-1:0]  den_q;
  logic [FRAC_W-1:0] q_q;
  logic [4:0]        k_q;
  logic              busy_q, done_q, ge;

  assign ge   = r_q >= {1'b0, den_q};
  assign rsub = ge ? r_q - {1'b0, den_q} : r_q;
  assign r_d  = {rsub[CNT_W-1:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
      r_q    <= '0;
      den_q  <= '0;
      q_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        k_q    <= '0;
        r_q    <= {1'b0, req_i.num};
        den_q  <= req_i.den;
      end else if (busy_q) begin
        q_q <= {q_q[FRAC_W-2:0], ge};
        r_q <= r_d;
        k_q <= k_q + 5'd1;
        if (k_q == 5'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule
